// ===== rtl/core/rci_pkg.sv =====
// Shared widths, stage records and arithmetic step functions for the ray/cylinder intersector.
package rci_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQ_STEPS  = 64;
  localparam int DIV_STEPS = 81;

  localparam logic [1:0] REG_Y_MIN   = 2'd0;
  localparam logic [1:0] REG_Y_MAX   = 2'd1;
  localparam logic [1:0] REG_CAPPED  = 2'd2;
  localparam logic [1:0] REG_EPSILON = 2'd3;

  localparam logic [31:0] NEG_INF = 32'h8000_0000;
  localparam logic [31:0] POS_INF = 32'h7FFF_FFFF;

  localparam logic signed [64:0] ONE_SQ = 65'sd1 <<< (2 * FRAC_BITS);

  typedef struct packed {
    logic [65:0]  rem;
    logic [63:0]  root;
    logic [127:0] rad;
  } sqrt_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [80:0] nq;
  } div_t;

  typedef struct packed {
    logic [63:0]        a;
    logic signed [64:0] b;
    logic               wall_go;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
    logic [31:0]        ady;
    logic signed [32:0] h_lo;
    logic signed [32:0] h_hi;
    logic [1:0]         cap_hit;
    logic [3:0]         num_neg;
  } side_t;

  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t       r;
    logic [67:0] acc;
    logic [67:0] trial;
    acc   = {s.rem, s.rad[127:126]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[125:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = 66'(acc - trial);
      r.root = {s.root[62:0], 1'b1};
    end else begin
      r.rem  = acc[65:0];
      r.root = {s.root[62:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_t div_step(div_t s, logic [63:0] den);
    div_t        r;
    logic [64:0] acc;
    acc = {s.rem, s.nq[80]};
    if (acc >= {1'b0, den}) begin
      r.rem = 64'(acc - {1'b0, den});
      r.nq  = {s.nq[79:0], 1'b1};
    end else begin
      r.rem = acc[63:0];
      r.nq  = {s.nq[79:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ray_cylinder_intersect.sv =====
// Capped unit-cylinder ray intersection pipeline with a result serializer.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, origin_*_i, dir_*_i     | to block
//  out     | out_valid_o, out_stall_i, hit/hit_t/kind/last_o | from block
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                 | to block
//
// A ray passes from acceptance to its first result beat through 6 product stages,
// 65 square-root stages, 82 division stages and 5 range-check stages, then the serializer.
// A ray can enter every cycle unless in_stall_o holds it; a ray holds the single result
// port for one beat per result, or one no-hit beat, so the result port sets the sustained rate.
// Reset clears the valid bits and loads the default register values.
// When a finished ray waits on a busy serializer, the whole pipeline holds in place.
module ray_cylinder_intersect
  import rci_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic signed [31:0] hit_t_o,
  output logic [1:0]         hit_kind_o,
  output logic               last_o
);

  logic signed [31:0] y_min_q, y_max_q;
  logic               capped_q;
  logic [15:0]        epsilon_q;
  logic               lo_inf, hi_inf;
  logic               adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_min_q   <= NEG_INF;
      y_max_q   <= POS_INF;
      capped_q  <= 1'b0;
      epsilon_q <= 16'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_Y_MIN:   y_min_q   <= cfg_data_i;
        REG_Y_MAX:   y_max_q   <= cfg_data_i;
        REG_CAPPED:  capped_q  <= cfg_data_i[0];
        REG_EPSILON: epsilon_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign lo_inf = (y_min_q == NEG_INF);
  assign hi_inf = (y_max_q == POS_INF);

  // Stage a: input registers.
  logic               va_q;
  logic signed [31:0] ox_a_q, oy_a_q, oz_a_q, dx_a_q, dy_a_q, dz_a_q;

  // Stage b: 32x32 products and cap heights.
  logic               vb_q;
  logic signed [63:0] dxdx_b_q, dzdz_b_q, oxdx_b_q, ozdz_b_q, oxox_b_q, ozoz_b_q;
  logic signed [63:0] oxdy_b_q, ozdy_b_q, dydy_b_q;
  logic signed [32:0] hlo_b_q, hhi_b_q;
  logic signed [31:0] dx_b_q, dz_b_q, dy_b_q, oy_b_q;

  // Stage c: quadratic coefficients, cap cross products.
  logic               vc_q;
  logic [63:0]        a_c_q;
  logic signed [64:0] b_c_q, c_c_q;
  logic               wall_ok_c_q;
  logic signed [64:0] hdxlo_c_q, hdzlo_c_q, hdxhi_c_q, hdzhi_c_q;
  logic signed [63:0] oxdy_c_q, ozdy_c_q, dydy_c_q;
  logic signed [31:0] dy_c_q, oy_c_q;
  logic signed [32:0] hlo_c_q, hhi_c_q;
  logic [63:0]        a_sum;

  // Stage d: partial products of B*B and A*C, cap X and Z.
  logic               vd_q;
  logic [63:0]        bbll_d_q, bblh_d_q, bbhh_d_q, acll_d_q, aclh_d_q, achl_d_q, achh_d_q;
  logic               cneg_d_q, wall_ok_d_q;
  logic [63:0]        a_d_q;
  logic signed [64:0] b_d_q;
  logic signed [65:0] cv_d_q [4];
  logic signed [63:0] dydy_d_q;
  logic signed [31:0] dy_d_q, oy_d_q;
  logic signed [32:0] hlo_d_q, hhi_d_q;
  logic [63:0]        bmag, cmag;

  // Stage e: B*B and A*C sums, cap square partials.
  logic               ve_q;
  logic [127:0]       bsq_e_q, ac_e_q;
  logic               cneg_e_q, wall_ok_e_q;
  logic [63:0]        a_e_q;
  logic signed [64:0] b_e_q;
  logic               big_e_q [4];
  logic [63:0]        pll_e_q [4];
  logic [47:0]        plh_e_q [4];
  logic [31:0]        phh_e_q [4];
  logic signed [63:0] dydy_e_q;
  logic signed [31:0] dy_e_q, oy_e_q;
  logic signed [32:0] hlo_e_q, hhi_e_q;
  logic [63:0]        cvmag [4];

  // Stage f: discriminant, cap squares.
  logic               vf_q;
  logic [127:0]       d_f_q;
  logic               wall_go_f_q;
  logic [63:0]        a_f_q;
  logic signed [64:0] b_f_q;
  logic               big_f_q [4];
  logic [95:0]        sq_f_q [4];
  logic signed [63:0] dydy_f_q;
  logic signed [31:0] dy_f_q, oy_f_q;
  logic signed [32:0] hlo_f_q, hhi_f_q;
  logic [129:0]       dsum;

  // Square-root chain and division chain.
  logic               sv_q [SQ_STEPS+1];
  sqrt_t              sq_q [SQ_STEPS+1];
  side_t              sd_q [SQ_STEPS+1];
  logic               dv_q [DIV_STEPS+1];
  div_t               dq_q [DIV_STEPS+1][4];
  side_t              dd_q [DIV_STEPS+1];

  logic [31:0]        ady_f;
  logic               cap_en;
  logic [96:0]        lsum [2];
  logic [96:0]        rlim;
  logic [1:0]         cap_hit_g;

  // Stage j to n: floor fix-up, saturation, y range check.
  logic               vj_q, vk_q, vl_q, vm_q, vn_q;
  logic [49:0]        cm_j_q [2];
  logic               tneg_j_q [2];
  logic signed [31:0] tsat_j_q [4];
  logic               wall_go_j_q, wall_go_k_q, wall_go_l_q, wall_go_m_q;
  logic signed [31:0] oy_j_q, oy_k_q, oy_l_q, dy_j_q;
  logic [31:0]        ady_j_q;
  logic [1:0]         cap_j_q, cap_k_q, cap_l_q, cap_m_q;
  logic [63:0]        plo_k_q [2];
  logic [49:0]        phi_k_q [2];
  logic               ys_k_q [2], ys_l_q [2];
  logic signed [31:0] tsat_k_q [4], tsat_l_q [4], tsat_m_q [4];
  logic [81:0]        prod_l_q [2];
  logic signed [83:0] y_m_q [2];
  logic [3:0]         mask_n_q;
  logic signed [31:0] t_n_q [4];

  // Serializer.
  logic               ov_q;
  logic [3:0]         om_q;
  logic signed [31:0] ot_q [4];
  logic [1:0]         oidx;
  logic               ser_free, ser_load, out_take;

  assign out_take = out_valid_o && !out_stall_i;
  assign ser_free = !ov_q || (out_take && last_o);
  assign ser_load = vn_q && ser_free;
  assign adv      = !vn_q || ser_free;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0; ve_q <= 1'b0; vf_q <= 1'b0;
      sv_q[0] <= 1'b0; dv_q[0] <= 1'b0;
      vj_q <= 1'b0; vk_q <= 1'b0; vl_q <= 1'b0; vm_q <= 1'b0; vn_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i; vb_q <= va_q; vc_q <= vb_q; vd_q <= vc_q; ve_q <= vd_q;
      vf_q <= ve_q; sv_q[0] <= vf_q; dv_q[0] <= sv_q[SQ_STEPS];
      vj_q <= dv_q[DIV_STEPS]; vk_q <= vj_q; vl_q <= vk_q; vm_q <= vl_q; vn_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_a_q <= origin_x_i; oy_a_q <= origin_y_i; oz_a_q <= origin_z_i;
      dx_a_q <= dir_x_i;    dy_a_q <= dir_y_i;    dz_a_q <= dir_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dxdx_b_q <= dx_a_q * dx_a_q;
      dzdz_b_q <= dz_a_q * dz_a_q;
      oxdx_b_q <= ox_a_q * dx_a_q;
      ozdz_b_q <= oz_a_q * dz_a_q;
      oxox_b_q <= ox_a_q * ox_a_q;
      ozoz_b_q <= oz_a_q * oz_a_q;
      oxdy_b_q <= ox_a_q * dy_a_q;
      ozdy_b_q <= oz_a_q * dy_a_q;
      dydy_b_q <= dy_a_q * dy_a_q;
      hlo_b_q  <= 33'(y_min_q) - 33'(oy_a_q);
      hhi_b_q  <= 33'(y_max_q) - 33'(oy_a_q);
      dx_b_q <= dx_a_q; dz_b_q <= dz_a_q; dy_b_q <= dy_a_q; oy_b_q <= oy_a_q;
    end
  end

  assign a_sum = 64'(dxdx_b_q) + 64'(dzdz_b_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_c_q       <= a_sum;
      b_c_q       <= 65'(oxdx_b_q) + 65'(ozdz_b_q);
      c_c_q       <= 65'(oxox_b_q) + 65'(ozoz_b_q) - ONE_SQ;
      wall_ok_c_q <= (a_sum != 64'd0) && (a_sum >= (64'(epsilon_q) << FRAC_BITS));
      hdxlo_c_q   <= hlo_b_q * dx_b_q;
      hdzlo_c_q   <= hlo_b_q * dz_b_q;
      hdxhi_c_q   <= hhi_b_q * dx_b_q;
      hdzhi_c_q   <= hhi_b_q * dz_b_q;
      oxdy_c_q <= oxdy_b_q; ozdy_c_q <= ozdy_b_q; dydy_c_q <= dydy_b_q;
      dy_c_q <= dy_b_q; oy_c_q <= oy_b_q; hlo_c_q <= hlo_b_q; hhi_c_q <= hhi_b_q;
    end
  end

  assign bmag = b_c_q[64] ? 64'(-b_c_q) : 64'(b_c_q);
  assign cmag = c_c_q[64] ? 64'(-c_c_q) : 64'(c_c_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bbll_d_q <= 64'(bmag[31:0]) * 64'(bmag[31:0]);
      bblh_d_q <= 64'(bmag[31:0]) * 64'(bmag[63:32]);
      bbhh_d_q <= 64'(bmag[63:32]) * 64'(bmag[63:32]);
      acll_d_q <= 64'(a_c_q[31:0]) * 64'(cmag[31:0]);
      aclh_d_q <= 64'(a_c_q[31:0]) * 64'(cmag[63:32]);
      achl_d_q <= 64'(a_c_q[63:32]) * 64'(cmag[31:0]);
      achh_d_q <= 64'(a_c_q[63:32]) * 64'(cmag[63:32]);
      cneg_d_q <= c_c_q[64];
      wall_ok_d_q <= wall_ok_c_q;
      a_d_q <= a_c_q; b_d_q <= b_c_q;
      cv_d_q[0] <= 66'(oxdy_c_q) + 66'(hdxlo_c_q);
      cv_d_q[1] <= 66'(ozdy_c_q) + 66'(hdzlo_c_q);
      cv_d_q[2] <= 66'(oxdy_c_q) + 66'(hdxhi_c_q);
      cv_d_q[3] <= 66'(ozdy_c_q) + 66'(hdzhi_c_q);
      dydy_d_q <= dydy_c_q; dy_d_q <= dy_c_q; oy_d_q <= oy_c_q;
      hlo_d_q <= hlo_c_q; hhi_d_q <= hhi_c_q;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      cvmag[j] = cv_d_q[j][65] ? 64'(-cv_d_q[j]) : 64'(cv_d_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bsq_e_q <= {bbhh_d_q, 64'd0} + (128'(bblh_d_q) << 33) + 128'(bbll_d_q);
      ac_e_q  <= {achh_d_q, 64'd0} + ((128'(aclh_d_q) + 128'(achl_d_q)) << 32)
                 + 128'(acll_d_q);
      for (int j = 0; j < 4; j++) begin
        big_e_q[j] <= (cvmag[j][63:48] != 16'd0);
        pll_e_q[j] <= 64'(cvmag[j][31:0]) * 64'(cvmag[j][31:0]);
        plh_e_q[j] <= 48'(cvmag[j][31:0]) * 48'(cvmag[j][47:32]);
        phh_e_q[j] <= 32'(cvmag[j][47:32]) * 32'(cvmag[j][47:32]);
      end
      cneg_e_q <= cneg_d_q; wall_ok_e_q <= wall_ok_d_q; a_e_q <= a_d_q; b_e_q <= b_d_q;
      dydy_e_q <= dydy_d_q; dy_e_q <= dy_d_q; oy_e_q <= oy_d_q;
      hlo_e_q <= hlo_d_q; hhi_e_q <= hhi_d_q;
    end
  end

  assign dsum = cneg_e_q ? ({2'b00, bsq_e_q} + {2'b00, ac_e_q})
                         : ({2'b00, bsq_e_q} - {2'b00, ac_e_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_f_q       <= dsum[127:0];
      wall_go_f_q <= wall_ok_e_q && !dsum[129];
      for (int j = 0; j < 4; j++) begin
        big_f_q[j] <= big_e_q[j];
        sq_f_q[j]  <= {phh_e_q[j], 64'd0} + (96'(plh_e_q[j]) << 33) + 96'(pll_e_q[j]);
      end
      a_f_q <= a_e_q; b_f_q <= b_e_q; dydy_f_q <= dydy_e_q; dy_f_q <= dy_e_q;
      oy_f_q <= oy_e_q; hlo_f_q <= hlo_e_q; hhi_f_q <= hhi_e_q;
    end
  end

  assign ady_f  = 32'(-dy_f_q) & {32{dy_f_q[31]}} | 32'(dy_f_q) & {32{!dy_f_q[31]}};
  assign cap_en = capped_q && (dy_f_q != 32'sd0) && (ady_f >= 32'(epsilon_q));
  assign rlim   = 97'(dydy_f_q) << (2 * FRAC_BITS);
  assign lsum[0] = 97'(sq_f_q[0]) + 97'(sq_f_q[1]);
  assign lsum[1] = 97'(sq_f_q[2]) + 97'(sq_f_q[3]);
  assign cap_hit_g[0] = cap_en && !lo_inf && !big_f_q[0] && !big_f_q[1] && (lsum[0] <= rlim);
  assign cap_hit_g[1] = cap_en && !hi_inf && !big_f_q[2] && !big_f_q[3] && (lsum[1] <= rlim);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      sq_q[0].rad  <= d_f_q;
      sd_q[0].a       <= a_f_q;
      sd_q[0].b       <= b_f_q;
      sd_q[0].wall_go <= wall_go_f_q;
      sd_q[0].oy      <= oy_f_q;
      sd_q[0].dy      <= dy_f_q;
      sd_q[0].ady     <= ady_f;
      sd_q[0].h_lo    <= hlo_f_q;
      sd_q[0].h_hi    <= hhi_f_q;
      sd_q[0].cap_hit <= cap_hit_g;
      sd_q[0].num_neg <= '0;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i+1] <= 1'b0;
      end else if (adv) begin
        sv_q[i+1] <= sv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[i+1] <= sqrt_step(sq_q[i]);
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  // Stage h: wall and cap numerators enter the dividers.
  logic signed [66:0] nb, sroot, n0, n1;
  logic [64:0]        n0mag, n1mag;
  logic [32:0]        hlomag, hhimag;
  side_t              side_h;

  assign sroot  = 67'(sq_q[SQ_STEPS].root);
  assign nb     = -67'(sd_q[SQ_STEPS].b);
  assign n0     = nb - sroot;
  assign n1     = nb + sroot;
  assign n0mag  = n0[66] ? 65'(-n0) : 65'(n0);
  assign n1mag  = n1[66] ? 65'(-n1) : 65'(n1);
  assign hlomag = sd_q[SQ_STEPS].h_lo[32] ? 33'(-sd_q[SQ_STEPS].h_lo)
                                          : 33'(sd_q[SQ_STEPS].h_lo);
  assign hhimag = sd_q[SQ_STEPS].h_hi[32] ? 33'(-sd_q[SQ_STEPS].h_hi)
                                          : 33'(sd_q[SQ_STEPS].h_hi);

  always_comb begin
    side_h = sd_q[SQ_STEPS];
    side_h.num_neg = {sd_q[SQ_STEPS].h_hi[32] ^ sd_q[SQ_STEPS].dy[31],
                      sd_q[SQ_STEPS].h_lo[32] ^ sd_q[SQ_STEPS].dy[31],
                      n1[66], n0[66]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dq_q[0][0] <= '{rem: '0, nq: {n0mag, 16'd0}};
      dq_q[0][1] <= '{rem: '0, nq: {n1mag, 16'd0}};
      dq_q[0][2] <= '{rem: '0, nq: {32'd0, hlomag, 16'd0}};
      dq_q[0][3] <= '{rem: '0, nq: {32'd0, hhimag, 16'd0}};
      dd_q[0]    <= side_h;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else if (adv) begin
        dv_q[i+1] <= dv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dq_q[i+1][0] <= div_step(dq_q[i][0], dd_q[i].a);
        dq_q[i+1][1] <= div_step(dq_q[i][1], dd_q[i].a);
        dq_q[i+1][2] <= div_step(dq_q[i][2], {32'd0, dd_q[i].ady});
        dq_q[i+1][3] <= div_step(dq_q[i][3], {32'd0, dd_q[i].ady});
        dd_q[i+1]    <= dd_q[i];
      end
    end
  end

  // Stage j: floor quotient, saturate, clamp for the range check.
  logic [81:0]        tmag [4];
  logic               tneg [4];
  logic signed [31:0] tsat [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tmag[k] = 82'(dq_q[DIV_STEPS][k].nq)
              + 82'(dd_q[DIV_STEPS].num_neg[k] && (dq_q[DIV_STEPS][k].rem != 64'd0));
      tneg[k] = dd_q[DIV_STEPS].num_neg[k] && (tmag[k] != 82'd0);
      if (!tneg[k]) begin
        tsat[k] = (tmag[k] > 82'(POS_INF)) ? POS_INF : tmag[k][31:0];
      end else begin
        tsat[k] = (tmag[k] > 82'(NEG_INF)) ? NEG_INF : (~tmag[k][31:0] + 32'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        cm_j_q[w]   <= (tmag[w] > (82'd1 << 49)) ? (50'd1 << 49) : tmag[w][49:0];
        tneg_j_q[w] <= tneg[w];
      end
      for (int k = 0; k < 4; k++) begin
        tsat_j_q[k] <= tsat[k];
      end
      wall_go_j_q <= dd_q[DIV_STEPS].wall_go;
      oy_j_q      <= dd_q[DIV_STEPS].oy;
      dy_j_q      <= dd_q[DIV_STEPS].dy;
      ady_j_q     <= dd_q[DIV_STEPS].ady;
      cap_j_q     <= dd_q[DIV_STEPS].cap_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        plo_k_q[w] <= 64'(cm_j_q[w][31:0]) * 64'(ady_j_q);
        phi_k_q[w] <= 50'(cm_j_q[w][49:32]) * 50'(ady_j_q);
        ys_k_q[w]  <= tneg_j_q[w] ^ dy_j_q[31];
      end
      tsat_k_q <= tsat_j_q;
      wall_go_k_q <= wall_go_j_q; oy_k_q <= oy_j_q; cap_k_q <= cap_j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        prod_l_q[w] <= (82'(phi_k_q[w]) << 32) + 82'(plo_k_q[w]);
      end
      ys_l_q <= ys_k_q;
      tsat_l_q <= tsat_k_q;
      wall_go_l_q <= wall_go_k_q; oy_l_q <= oy_k_q; cap_l_q <= cap_k_q;
    end
  end

  logic signed [83:0] oys, lo_s, hi_s;
  assign oys  = 84'(oy_l_q) <<< FRAC_BITS;
  assign lo_s = 84'(y_min_q) <<< FRAC_BITS;
  assign hi_s = 84'(y_max_q) <<< FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        y_m_q[w] <= ys_l_q[w] ? (oys - $signed(84'(prod_l_q[w])))
                              : (oys + $signed(84'(prod_l_q[w])));
      end
      tsat_m_q <= tsat_l_q;
      wall_go_m_q <= wall_go_l_q; cap_m_q <= cap_l_q;
    end
  end

  logic [1:0] wall_hit;
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      wall_hit[w] = wall_go_m_q && (lo_inf || (lo_s < y_m_q[w])) && (hi_inf || (y_m_q[w] < hi_s));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mask_n_q <= {cap_m_q, wall_hit};
      t_n_q    <= tsat_m_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      om_q <= '0;
    end else if (ser_load) begin
      ov_q <= 1'b1;
      om_q <= mask_n_q;
    end else if (out_take && last_o) begin
      ov_q <= 1'b0;
    end else if (out_take) begin
      om_q <= om_q & (om_q - 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ot_q <= t_n_q;
    end
  end

  always_comb begin
    if (om_q[0]) begin
      oidx = 2'd0;
    end else if (om_q[1]) begin
      oidx = 2'd1;
    end else if (om_q[2]) begin
      oidx = 2'd2;
    end else begin
      oidx = 2'd3;
    end
  end

  assign out_valid_o = ov_q;
  assign hit_o       = (om_q != 4'd0);
  assign hit_kind_o  = hit_o ? oidx : 2'd0;
  assign hit_t_o     = hit_o ? ot_q[oidx] : 32'sd0;
  assign last_o      = ((om_q & (om_q - 4'd1)) == 4'd0);

  // The no-hit beat always closes its ray.
  a_nohit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> last_o && hit_t_o == 32'sd0)
    else $error("no-hit beat without last");

  // A ray with more beats keeps the port valid after a taken beat.
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("result burst broken");

  // Kinds within one ray rise strictly.
  a_kind_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> hit_kind_o > $past(hit_kind_o))
    else $error("result kinds out of order");

  // A finished ray waiting on a busy serializer is held.
  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vn_q && !ser_free |=> vn_q && $stable(mask_n_q))
    else $error("pipeline tail lost a ray");

endmodule
